// ===== design/vdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_pkg
// Types and constants shared by the front end, the queue and the back end
// of the vector distance unit.
// ----------------------------------------------------------------------------
package vdu_pkg;

  localparam int COORD_W  = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ACC_W    = 48;
  localparam int DIST_W   = 24;
  localparam int METRIC_W = 2;

  // One square root step resolves one result bit, two accumulator bits.
  localparam int SQRT_STEPS = ACC_W / 2;
  localparam int STEP_W     = $clog2(SQRT_STEPS);

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [METRIC_W-1:0] METRIC_EUCLIDEAN = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_CHEBYSHEV = 2'd2;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [SQ_W-1:0]     sq;
    logic [MAG_W-1:0]    mag;
    logic [METRIC_W-1:0] metric;
    logic                last;
  } entry_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== design/vdu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_front
// Accepts coordinate pairs, forms the absolute difference and its square,
// and tags each request with the metric in force when it arrived.
// ----------------------------------------------------------------------------
module vdu_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vdu_pkg::COORD_W-1:0]    coord_a,
  input  logic signed [vdu_pkg::COORD_W-1:0]    coord_b,
  input  logic                                  last,
  input  logic        [vdu_pkg::METRIC_W-1:0]   metric,
  output logic                                  push,
  output vdu_pkg::entry_t                       push_entry,
  input  logic                                  push_ready
);

  logic signed [vdu_pkg::COORD_W:0]   diff;
  logic        [vdu_pkg::COORD_W:0]   diff_neg;
  logic        [vdu_pkg::MAG_W-1:0]   mag_in;

  logic                               s_valid;
  logic        [vdu_pkg::MAG_W-1:0]   s_mag;
  logic        [vdu_pkg::METRIC_W-1:0] s_metric;
  logic                               s_last;

  // The difference needs seventeen bits; its magnitude fits in sixteen.
  assign diff     = {coord_a[vdu_pkg::COORD_W-1], coord_a}
                  - {coord_b[vdu_pkg::COORD_W-1], coord_b};
  assign diff_neg = -diff;
  assign mag_in   = diff[vdu_pkg::COORD_W] ? diff_neg[vdu_pkg::MAG_W-1:0]
                                           : diff[vdu_pkg::MAG_W-1:0];

  assign push     = s_valid && push_ready;
  assign in_ready = !s_valid || push_ready;

  always_comb begin
    push_entry.sq     = s_mag * s_mag;
    push_entry.mag    = s_mag;
    push_entry.metric = s_metric;
    push_entry.last   = s_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s_mag    <= mag_in;
      s_metric <= metric;
      s_last   <= last;
    end
  end

endmodule

// ===== design/vdu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_queue
// Two-entry queue between the front end and the back end, so that either
// side may stall without holding up the other at once.
// ----------------------------------------------------------------------------
module vdu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vdu_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output vdu_pkg::head_t  head
);

  vdu_pkg::entry_t slot [2];
  logic [1:0]      count;

  assign push_ready = (count != 2'd2) || pop;
  assign head.valid = (count != 2'd0);
  assign head.entry = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push && pop) begin
      if (count == 2'd1) begin
        slot[0] <= push_entry;
      end else begin
        slot[0] <= slot[1];
        slot[1] <= push_entry;
      end
    end else if (pop) begin
      slot[0] <= slot[1];
    end else if (push) begin
      slot[count[0]] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== design/vdu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_back
// Folds each request into the accumulator, takes the square root for the
// Euclidean metric bit by bit, and holds the result for the receiver.
// ----------------------------------------------------------------------------
module vdu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  vdu_pkg::head_t                 head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vdu_pkg::DIST_W-1:0]     distance
);

  typedef enum logic {ST_RUN, ST_SQRT} state_t;

  state_t                         state;
  logic [vdu_pkg::ACC_W-1:0]      acc;
  logic [vdu_pkg::ACC_W-1:0]      acc_next;
  logic [vdu_pkg::ACC_W:0]        sum_sq;
  logic [vdu_pkg::ACC_W:0]        sum_mag;
  logic [vdu_pkg::ACC_W-1:0]      mag_ext;
  logic                           pop_ready;
  logic                           load_result;

  logic [vdu_pkg::ACC_W-1:0]      rem;
  logic [vdu_pkg::ACC_W-1:0]      root;
  logic [vdu_pkg::STEP_W-1:0]     step;
  logic [vdu_pkg::ACC_W-1:0]      bit_w;
  logic [vdu_pkg::ACC_W-1:0]      trial;
  logic [vdu_pkg::ACC_W-1:0]      rem_next;
  logic [vdu_pkg::ACC_W-1:0]      root_next;

  assign mag_ext = {{(vdu_pkg::ACC_W - vdu_pkg::MAG_W){1'b0}}, head.entry.mag};
  assign sum_sq  = {1'b0, acc}
                 + {{(vdu_pkg::ACC_W + 1 - vdu_pkg::SQ_W){1'b0}}, head.entry.sq};
  assign sum_mag = {1'b0, acc} + {1'b0, mag_ext};

  always_comb begin
    case (head.entry.metric)
      vdu_pkg::METRIC_EUCLIDEAN: begin
        acc_next = sum_sq[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX
                                          : sum_sq[vdu_pkg::ACC_W-1:0];
      end
      vdu_pkg::METRIC_MANHATTAN: begin
        acc_next = sum_mag[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX
                                           : sum_mag[vdu_pkg::ACC_W-1:0];
      end
      default: begin
        acc_next = (mag_ext > acc) ? mag_ext : acc;
      end
    endcase
  end

  // A closing request needs the output register free, since it either
  // fills it now or leaves it to the square root, which nothing else touches.
  assign pop_ready = (state == ST_RUN)
                   && (!head.entry.last || !out_valid || out_ready);
  assign pop       = head.valid && pop_ready;

  // The output register loads a closing Manhattan or Chebyshev request at
  // once, or the root after its final step.
  assign load_result = (pop && head.entry.last
                        && (head.entry.metric != vdu_pkg::METRIC_EUCLIDEAN))
                     || ((state == ST_SQRT) && (step == '0));

  // One step of the digit-by-digit square root.
  always_comb begin
    bit_w = {{(vdu_pkg::ACC_W - 1){1'b0}}, 1'b1} << {step, 1'b0};
    trial = root + bit_w;
    if (rem >= trial) begin
      rem_next  = rem - trial;
      root_next = (root >> 1) + bit_w;
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (pop) begin
            if (!head.entry.last) begin
              acc <= acc_next;
            end else begin
              acc <= '0;
              if (head.entry.metric == vdu_pkg::METRIC_EUCLIDEAN) begin
                rem   <= acc_next;
                root  <= '0;
                step  <= vdu_pkg::STEP_W'(vdu_pkg::SQRT_STEPS - 1);
                state <= ST_SQRT;
              end else begin
                distance <= (|acc_next[vdu_pkg::ACC_W-1:vdu_pkg::DIST_W])
                          ? vdu_pkg::DIST_MAX : acc_next[vdu_pkg::DIST_W-1:0];
              end
            end
          end
        end
        ST_SQRT: begin
          rem  <= rem_next;
          root <= root_next;
          if (step == '0) begin
            distance <= root_next[vdu_pkg::DIST_W-1:0];
            state    <= ST_RUN;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sqrt_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> !out_valid)
    else $error("result pending while square root runs");
  a_sqrt_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> !pop)
    else $error("request taken while square root runs");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.entry.last) |=> (acc == '0))
    else $error("accumulator not cleared after closing request");
`endif

endmodule

// ===== design/vector_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_unit
// Streaming Euclidean, Manhattan or Chebyshev distance between two vectors.
// ----------------------------------------------------------------------------
// Usage: each input request carries one signed Q8.8 coordinate of each
// vector and a last flag, on a valid/ready channel. The request with last
// set closes the vector and yields one distance (unsigned Q16.8, saturated)
// on the output valid/ready channel; other requests yield nothing.
// The metric register is written through cfg_wr_en/cfg_wr_data while idle;
// it is 0 after reset (Euclidean, 1 Manhattan, 2 or 3 Chebyshev).
// Throughput: one coordinate pair per cycle while the vector streams and
// the back end does not stall. A closing Manhattan or Chebyshev request
// passes the front-end register and the queue into the output register;
// a Euclidean one goes to the square root, which resolves one root bit per
// cycle, while the front end and the two-entry queue take up to three requests.
// Reset clears the accumulator, the queue and any pending result.
// If the receiver stalls, the result waits in the output register; the
// block keeps accumulating the next vector and stalls only on a second
// closing request.
// ----------------------------------------------------------------------------
module vector_distance_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic        [vdu_pkg::METRIC_W-1:0]  cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vdu_pkg::COORD_W-1:0]   coord_a,
  input  logic signed [vdu_pkg::COORD_W-1:0]   coord_b,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [vdu_pkg::DIST_W-1:0]    distance
);

  logic [vdu_pkg::METRIC_W-1:0] metric;
  logic                         push;
  logic                         push_ready;
  vdu_pkg::entry_t              push_entry;
  logic                         pop;
  vdu_pkg::head_t               head;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= vdu_pkg::METRIC_EUCLIDEAN;
    end else if (cfg_wr_en) begin
      metric <= cfg_wr_data;
    end
  end

  vdu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coord_a    (coord_a),
    .coord_b    (coord_b),
    .last       (last),
    .metric     (metric),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  vdu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  vdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector distance unit. Coordinate pairs are
// driven on the input channel while a behavioural predictor folds each taken
// request into its own accumulator; every distance that leaves the block is
// compared with the oldest predicted one. Directed tests cover the field
// extremes, all metric codes, saturation and metric changes inside a vector;
// random phases then vary vector length, content and idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  // Longest path through the block is the Euclidean root plus queue slack.
  localparam int SETTLE_CYCLES = 40;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [vdu_pkg::METRIC_W-1:0]        cfg_wr_data;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [vdu_pkg::COORD_W-1:0]  coord_a;
  logic signed [vdu_pkg::COORD_W-1:0]  coord_b;
  logic                                last;
  logic                                out_valid;
  logic                                out_ready;
  logic [vdu_pkg::DIST_W-1:0]          distance;

  vector_distance_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance)
  );

  // Predictor state.
  logic [vdu_pkg::METRIC_W-1:0] metric_model;
  logic [vdu_pkg::ACC_W-1:0]    acc_model;
  logic [vdu_pkg::DIST_W-1:0]   pending_distances[$];

  int errors;
  int pairs_sent;
  int distances_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [vdu_pkg::DIST_W-1:0] floor_root(
      input logic [vdu_pkg::ACC_W-1:0] v);
    logic [vdu_pkg::DIST_W-1:0] root;
    logic [vdu_pkg::DIST_W-1:0] trial;
    logic [vdu_pkg::ACC_W-1:0]  trial_sq;
    root = '0;
    for (int i = vdu_pkg::DIST_W - 1; i >= 0; i--) begin
      trial    = root | (vdu_pkg::DIST_W'(1) << i);
      trial_sq = vdu_pkg::ACC_W'(trial) * vdu_pkg::ACC_W'(trial);
      if (trial_sq <= v) root = trial;
    end
    return root;
  endfunction

  // Folds one taken request into the predicted accumulator and, on a closing
  // request, queues the distance that the block must produce.
  task automatic fold_pair(input logic signed [vdu_pkg::COORD_W-1:0] a,
                           input logic signed [vdu_pkg::COORD_W-1:0] b,
                           input logic lst);
    logic signed [vdu_pkg::COORD_W:0] diff;
    logic [vdu_pkg::MAG_W-1:0]        mag;
    logic [vdu_pkg::SQ_W-1:0]         sq;
    logic [vdu_pkg::ACC_W:0]          sum;
    logic [vdu_pkg::DIST_W-1:0]       dist_exp;
    diff = (vdu_pkg::COORD_W + 1)'(a) - (vdu_pkg::COORD_W + 1)'(b);
    mag  = diff[vdu_pkg::COORD_W] ? vdu_pkg::MAG_W'(-diff) : diff[vdu_pkg::MAG_W-1:0];
    sq   = vdu_pkg::SQ_W'(mag) * vdu_pkg::SQ_W'(mag);
    case (metric_model)
      vdu_pkg::METRIC_EUCLIDEAN: begin
        sum       = (vdu_pkg::ACC_W + 1)'(acc_model) + (vdu_pkg::ACC_W + 1)'(sq);
        acc_model = sum[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX : sum[vdu_pkg::ACC_W-1:0];
      end
      vdu_pkg::METRIC_MANHATTAN: begin
        sum       = (vdu_pkg::ACC_W + 1)'(acc_model) + (vdu_pkg::ACC_W + 1)'(mag);
        acc_model = sum[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX : sum[vdu_pkg::ACC_W-1:0];
      end
      default: begin
        if (vdu_pkg::ACC_W'(mag) > acc_model) acc_model = vdu_pkg::ACC_W'(mag);
      end
    endcase
    if (lst) begin
      if (metric_model == vdu_pkg::METRIC_EUCLIDEAN) begin
        dist_exp = floor_root(acc_model);
      end else if (acc_model > vdu_pkg::ACC_W'(vdu_pkg::DIST_MAX)) begin
        dist_exp = vdu_pkg::DIST_MAX;
      end else begin
        dist_exp = acc_model[vdu_pkg::DIST_W-1:0];
      end
      pending_distances.push_back(dist_exp);
      acc_model = '0;
    end
  endtask

  task automatic send_pair(input logic signed [vdu_pkg::COORD_W-1:0] a,
                           input logic signed [vdu_pkg::COORD_W-1:0] b,
                           input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      coord_a  <= vdu_pkg::COORD_W'($urandom);
      coord_b  <= vdu_pkg::COORD_W'($urandom);
      last     <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_a  <= a;
    coord_b  <= b;
    last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_pair(a, b, lst);
    pairs_sent++;
  endtask

  // Stops offering requests and waits until the block has nothing left.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_metric(input logic [vdu_pkg::METRIC_W-1:0] m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    metric_model = m;
  endtask

  function automatic logic signed [vdu_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return vdu_pkg::COORD_W'($urandom_range(16)) - 16'sd8;
      default: return vdu_pkg::COORD_W'($urandom);
    endcase
  endfunction

  task automatic test_field_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh0001, 16'sh0000, 1'b1);
    send_pair(16'shFFFF, 16'sh0000, 1'b1);
    send_pair(16'sh0100, 16'shFF00, 1'b0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8000, 16'sh0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_each_metric();
    logic [vdu_pkg::METRIC_W-1:0] m;
    for (int i = 0; i < 4; i++) begin
      m = vdu_pkg::METRIC_W'(i);
      set_metric(m);
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh0003, 16'shFFFD, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sh0005, 16'sh0002, 1'b1);
      wait_drained();
    end
    set_metric(vdu_pkg::METRIC_EUCLIDEAN);
  endtask

  // Each request must use the metric in force when it is taken.
  task automatic test_metric_change_midvector();
    set_metric(vdu_pkg::METRIC_MANHATTAN);
    send_pair(16'sh0200, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0300, 1'b0);
    wait_drained();
    set_metric(vdu_pkg::METRIC_CHEBYSHEV);
    send_pair(16'sh0100, 16'sh0000, 1'b0);
    send_pair(16'sh4000, 16'shC000, 1'b0);
    wait_drained();
    set_metric(vdu_pkg::METRIC_EUCLIDEAN);
    send_pair(16'sh0010, 16'sh0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_result_saturation();
    set_metric(vdu_pkg::METRIC_MANHATTAN);
    for (int i = 0; i < 260; i++) begin
      send_pair(16'sh7FFF, 16'sh8000, i == 259);
    end
    send_pair(16'sh0001, 16'sh0000, 1'b1);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering closing requests,
  // so the block has to stall its input.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_metric(vdu_pkg::METRIC_MANHATTAN);
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      send_pair(pick_coord(), pick_coord(), $urandom_range(2) == 0);
    end
    send_pair(pick_coord(), pick_coord(), 1'b1);
    wait_drained();
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                  input int pair_count);
    int target;
    int len;
    int r;
    logic signed [vdu_pkg::COORD_W-1:0] a;
    logic signed [vdu_pkg::COORD_W-1:0] b;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = pairs_sent + pair_count;
    while (pairs_sent < target) begin
      if ($urandom_range(7) == 0) begin
        wait_drained();
        set_metric(vdu_pkg::METRIC_W'($urandom_range(3)));
      end
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(6, 1);
      end else if (r < 97) begin
        len = $urandom_range(30, 7);
      end else begin
        len = $urandom_range(300, 100);
      end
      for (int i = 0; i < len; i++) begin
        a = pick_coord();
        b = ($urandom_range(3) == 0)
          ? a + (vdu_pkg::COORD_W'($urandom_range(6)) - 16'sd3)
          : pick_coord();
        if (i != len - 1 && $urandom_range(49) == 0) begin
          wait_drained();
          set_metric(vdu_pkg::METRIC_W'($urandom_range(3)));
        end
        send_pair(a, b, i == len - 1);
      end
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(31, 68, 150);
    run_random_phase(68, 31, 150);
    run_random_phase(0, 0, 150);
  endtask

  // Receiver side: random idling, with an occasional long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_distances.size() == 0) begin
        $error("distance: no request pending, actual %0d", distance);
        errors++;
      end else begin
        if (distance !== pending_distances[0]) begin
          $error("distance mismatch: expected %0d, actual %0d",
                 pending_distances[0], distance);
          errors++;
        end
        void'(pending_distances.pop_front());
        distances_checked++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_valid          = 1'b0;
    coord_a           = '0;
    coord_b           = '0;
    last              = 1'b0;
    errors            = 0;
    pairs_sent        = 0;
    distances_checked = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_request      = 0;
    metric_model      = vdu_pkg::METRIC_EUCLIDEAN;
    acc_model         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_each_metric();
    test_metric_change_midvector();
    test_result_saturation();
    test_back_pressure();
    test_random_traffic();
    wait_drained();

    $display("Run covered %0d coordinate pairs and %0d distances checked,", pairs_sent,
             distances_checked);
    $display("over all metric codes, result saturation, mid-vector changes and stalls.");
    if (errors == 0 && pending_distances.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
